// File: src/ddq_pkg.sv
// ddq_pkg: shared types and defaults for the double-ended queue.
// Request codes, per-cell shift operations and default sizes.
// No dependencies.
package ddq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MODE_W         = 3;
    localparam int VALUE_W        = 32;
    localparam int OCC_W          = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_PEEK       = 3'd4
    } t_mode;

    // What every cell of a chain does at a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_SHR  = 2'd1,   // take left neighbor, cell 0 takes the new value
        CELL_SHL  = 2'd2,   // take right neighbor
        CELL_PUT  = 2'd3    // the cell at the tail position takes the new value
    } t_cell_op;

endpackage

// File: src/double_ended_queue.sv
// double_ended_queue: bounded deque built from two shift chains of cells.
// Depends on ddq_pkg, ddq_chain, ddq_cell.
//
//   channel  direction  handshake               payload
//   in       to block   i_in_valid / o_in_stall  mode, value
//   out      from block o_out_valid / i_out_stall front, back, occupancy, flags
//
// One request per cycle while the input is not stalled; the result is registered
// and shows in the cycle after the transfer. The count and cells chain between requests.
// The front chain keeps element 0 in cell 0, the back chain keeps the last
// element in cell 0, so both ends are read from fixed cells.
// Reset clears the count and the result valid; cell contents are not reset.
// Input is stalled only while a result is waiting and the output is stalled.
module double_ended_queue import ddq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [MODE_W-1:0]         i_in_mode,
    input  logic signed [VALUE_W-1:0] i_in_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_out_front_value,
    output logic signed [VALUE_W-1:0] o_out_back_value,
    output logic [OCC_W-1:0]          o_out_occupancy,
    output logic                      o_out_is_empty,
    output logic                      o_out_is_full,
    output logic                      o_out_rejected
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    logic signed [VALUE_W-1:0] r_front, r_back;
    logic [OCC_W-1:0]  r_occ;
    logic              r_empty, r_full, r_rej;

    logic              in_xfer, out_xfer;
    logic              is_full, is_empty, refused;
    t_cell_op          op_front, op_back;
    logic [63:0]       value_ext;
    logic [DATA_WIDTH-1:0] store_value;
    logic [DATA_WIDTH-1:0] front_next, back_next;
    logic [63:0]       front_sext, back_sext;
    logic [31:0]       count_ext;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;
    assign out_xfer   = r_out_valid & ~i_out_stall;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    assign value_ext   = {32'b0, i_in_value};
    assign store_value = value_ext[DATA_WIDTH-1:0];

    always_comb begin
        op_front = CELL_HOLD;
        op_back  = CELL_HOLD;
        n_count  = r_count;
        refused  = 1'b0;
        if (in_xfer) begin
            unique case (i_in_mode)
                MODE_PUSH_FRONT: begin
                    if (is_full) begin
                        refused = 1'b1;
                    end else begin
                        op_front = CELL_SHR;
                        op_back  = CELL_PUT;
                        n_count  = r_count + 1'b1;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (is_full) begin
                        refused = 1'b1;
                    end else begin
                        op_front = CELL_PUT;
                        op_back  = CELL_SHR;
                        n_count  = r_count + 1'b1;
                    end
                end
                MODE_POP_FRONT: begin
                    if (is_empty) begin
                        refused = 1'b1;
                    end else begin
                        op_front = CELL_SHL;
                        n_count  = r_count - 1'b1;
                    end
                end
                MODE_POP_BACK: begin
                    if (is_empty) begin
                        refused = 1'b1;
                    end else begin
                        op_back = CELL_SHL;
                        n_count = r_count - 1'b1;
                    end
                end
                default: ;  // peek and unused codes
            endcase
        end
    end

    ddq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_op        (op_front),
        .i_count     (r_count),
        .i_value     (store_value),
        .o_head_next (front_next)
    );

    ddq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_op        (op_back),
        .i_count     (r_count),
        .i_value     (store_value),
        .o_head_next (back_next)
    );

    assign front_sext = 64'(signed'(front_next));
    assign back_sext  = 64'(signed'(back_next));
    assign count_ext  = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_front <= (n_count == '0) ? '0 : signed'(front_sext[VALUE_W-1:0]);
            r_back  <= (n_count == '0) ? '0 : signed'(back_sext[VALUE_W-1:0]);
            r_occ   <= count_ext[OCC_W-1:0];
            r_empty <= (n_count == '0);
            r_full  <= (n_count == CNT_W'(DEPTH));
            r_rej   <= refused;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_front_value = r_front;
    assign o_out_back_value  = r_back;
    assign o_out_occupancy   = r_occ;
    assign o_out_is_empty    = r_empty;
    assign o_out_is_full     = r_full;
    assign o_out_rejected    = r_rej;

endmodule

// File: src/ddq_cell.sv
// ddq_cell: one storage cell of a shift chain.
// Holds one element and moves it to or from its neighbors.
// Depends on ddq_pkg.
module ddq_cell import ddq_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_next
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_SHR: n_data = i_left;
            CELL_SHL: n_data = i_right;
            CELL_PUT: n_data = (i_count == CNT_W'(IDX)) ? i_value : r_data;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule

// File: src/ddq_chain.sv
// ddq_chain: a row of DEPTH cells, element 0 in cell 0.
// Reports the next value of cell 0 for the result register.
// Depends on ddq_pkg and ddq_cell.
module ddq_chain import ddq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic [DATA_WIDTH-1:0] o_head_next
);

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_next [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end

        // last cell keeps its own data on a left shift; it falls past the count
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        ddq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_count (i_count),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_next  (w_next[g])
        );
    end

    assign o_head_next = w_next[0];

endmodule

// File: src/ddq_checker.sv
// ddq_checker: port-level checks for double_ended_queue, attached by bind.
// Depends on ddq_pkg.
module ddq_checker import ddq_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic [MODE_W-1:0]         i_in_mode,
    input logic signed [VALUE_W-1:0] i_in_value,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [VALUE_W-1:0] o_out_front_value,
    input logic signed [VALUE_W-1:0] o_out_back_value,
    input logic [OCC_W-1:0]          o_out_occupancy,
    input logic                      o_out_is_empty,
    input logic                      o_out_is_full,
    input logic                      o_out_rejected
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // a waiting result keeps its values, occupancy and rejected flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_front_value) && $stable(o_out_back_value)
             && $stable(o_out_occupancy) && $stable(o_out_rejected)))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_is_empty) |->
            (o_out_occupancy == '0 && o_out_front_value == '0
             && o_out_back_value == '0 && !o_out_is_full))
        else $error("empty result with data or count");

    // every transfer in yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("no result after input transfer");

    a_push_front_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_mode == MODE_PUSH_FRONT) |=>
            (o_out_rejected || DATA_WIDTH < VALUE_W
             || o_out_front_value == $past(i_in_value)))
        else $error("pushed front value not at front");

    a_peek_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_mode[2]) |=> !o_out_rejected)
        else $error("peek flagged rejected");

endmodule

bind double_ended_queue ddq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ddq_checker (.*);

// File: test/tb_double_ended_queue.sv
// tb_double_ended_queue: self-checking bench for the double_ended_queue block.
// A ring-buffer predictor checks every result field; stimulus is directed, then
// random fill/drain sweeps under varying sender gaps and receiver stalls. Needs ddq_pkg.
module tb_double_ended_queue;
    import ddq_pkg::*;

    localparam int DEPTH           = DEPTH_DEF;
    localparam int RANDOM_ITEMS    = 1800;
    localparam int SWEEP_LEN       = 48;
    localparam logic [MODE_W-1:0] MODE_MAX = '1;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_deque_req;

    typedef struct {
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic [OCC_W-1:0]          occupancy;
        logic                      is_empty;
        logic                      is_full;
        logic                      rejected;
    } t_deque_view;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic [MODE_W-1:0]         i_in_mode   = MODE_PEEK;
    logic signed [VALUE_W-1:0] i_in_value  = '0;
    logic                      i_out_stall = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic signed [VALUE_W-1:0] o_out_front_value;
    logic signed [VALUE_W-1:0] o_out_back_value;
    logic [OCC_W-1:0]          o_out_occupancy;
    logic                      o_out_is_empty;
    logic                      o_out_is_full;
    logic                      o_out_rejected;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_mode         (i_in_mode),
        .i_in_value        (i_in_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_front_value (o_out_front_value),
        .o_out_back_value  (o_out_back_value),
        .o_out_occupancy   (o_out_occupancy),
        .o_out_is_empty    (o_out_is_empty),
        .o_out_is_full     (o_out_is_full),
        .o_out_rejected    (o_out_rejected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_deque_req  pending_reqs[$];
    t_deque_view predicted_views[$];

    // predictor state
    logic signed [VALUE_W-1:0] ring_model [DEPTH];
    int ring_head  = 0;
    int ring_count = 0;

    int total_reqs     = 0;
    int accepted_reqs  = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int rejected_seen  = 0;
    int full_seen      = 0;
    int empty_seen     = 0;

    function automatic t_deque_view deque_apply(input logic [MODE_W-1:0] mode,
                                                input logic signed [VALUE_W-1:0] value);
        t_deque_view v;
        v.rejected = 1'b0;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (ring_count == DEPTH) begin
                    v.rejected = 1'b1;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_model[ring_head] = value;
                    ring_count++;
                end
            end
            MODE_PUSH_BACK: begin
                if (ring_count == DEPTH) begin
                    v.rejected = 1'b1;
                end else begin
                    ring_model[(ring_head + ring_count) % DEPTH] = value;
                    ring_count++;
                end
            end
            MODE_POP_FRONT: begin
                if (ring_count == 0) begin
                    v.rejected = 1'b1;
                end else begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            MODE_POP_BACK: begin
                if (ring_count == 0) v.rejected = 1'b1;
                else ring_count--;
            end
            default: ;  // peek and unused codes leave the deque alone
        endcase
        if (ring_count == 0) begin
            v.front_value = '0;
            v.back_value  = '0;
        end else begin
            v.front_value = ring_model[ring_head];
            v.back_value  = ring_model[(ring_head + ring_count - 1) % DEPTH];
        end
        v.occupancy = OCC_W'(ring_count);
        v.is_empty  = (ring_count == 0);
        v.is_full   = (ring_count == DEPTH);
        return v;
    endfunction

    // sender gap / receiver stall percentages by run phase
    function automatic int sender_gap_pct();
        int ph;
        ph = (total_reqs == 0) ? 0 : accepted_reqs * 3 / total_reqs;
        return (ph == 0) ? 6 : (ph == 1) ? 58 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        int ph;
        ph = (total_reqs == 0) ? 0 : accepted_reqs * 3 / total_reqs;
        return (ph == 0) ? 58 : (ph == 1) ? 6 : 0;
    endfunction

    task automatic add_req(input logic [MODE_W-1:0] mode,
                           input logic signed [VALUE_W-1:0] value);
        t_deque_req r;
        r.mode  = mode;
        r.value = value;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s mismatch: expected 'h%08h, got 'h%08h", name, want, got);
        end
    endtask

    // driver: presents queued requests, predicts each transfer
    always @(posedge i_clk) begin : feed_proc
        t_deque_view v;
        t_deque_req  r;
        logic        next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                v = deque_apply(i_in_mode, i_in_value);
                predicted_views.insert(predicted_views.size(), v);
                accepted_reqs++;
                if (v.rejected) rejected_seen++;
                if (v.is_full) full_seen++;
                if (v.is_empty) empty_seen++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_reqs.size() != 0 &&
                    $urandom_range(99) >= sender_gap_pct()) begin
                r = pending_reqs[0];
                pending_reqs.delete(0);
                i_in_mode  <= r.mode;
                i_in_value <= r.value;
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
        end
    end

    // monitor: compares each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_proc
        t_deque_view want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (predicted_views.size() == 0) begin
                    fail_count++;
                    $error("result transfer with no prediction pending");
                end else begin
                    want = predicted_views[0];
                    predicted_views.delete(0);
                    check_field("front_value", want.front_value, o_out_front_value);
                    check_field("back_value", want.back_value, o_out_back_value);
                    check_field("occupancy", VALUE_W'(want.occupancy),
                                VALUE_W'(o_out_occupancy));
                    check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(o_out_is_empty));
                    check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(o_out_is_full));
                    check_field("rejected", VALUE_W'(want.rejected), VALUE_W'(o_out_rejected));
                end
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct());
        end
    end

    initial begin : run_proc
        int                        spin;
        int                        push_pct;
        int                        roll;
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;

        // directed: empty corner cases, last-element pops, value extremes, full
        add_req(MODE_PEEK, VAL_MAX);
        add_req(MODE_POP_FRONT, '0);
        add_req(MODE_POP_BACK, '1);
        add_req(MODE_MAX, VAL_MIN);
        add_req(MODE_PUSH_FRONT, VAL_MAX);
        add_req(MODE_POP_BACK, '0);
        add_req(MODE_PUSH_BACK, VAL_MIN);
        add_req(MODE_POP_FRONT, '0);
        for (int k = 0; k < DEPTH; k++) begin
            case (k % 4)
                0: value = '1;
                1: value = '0;
                2: value = {(VALUE_W/2){2'b10}};
                default: value = {(VALUE_W/2){2'b01}};
            endcase
            add_req((k % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, value);
        end
        add_req(MODE_PUSH_BACK, VAL_MAX);
        add_req(MODE_PUSH_FRONT, VAL_MIN);
        add_req(MODE_W'(MODE_PEEK + 1), '0);

        // random: alternating fill-leaning and drain-leaning sweeps
        push_pct = 25;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % SWEEP_LEN == 0) push_pct = (push_pct > 46) ? 25 : 67;
            roll = $urandom_range(99);
            if (roll < 8)
                mode = MODE_W'($urandom_range(MODE_MAX, MODE_PEEK));
            else if (roll < 8 + push_pct)
                mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else
                mode = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
            case ($urandom_range(19))
                0: value = VAL_MAX;
                1: value = VAL_MIN;
                2: value = '0;
                3: value = '1;
                default: value = $urandom;
            endcase
            add_req(mode, value);
        end
        total_reqs = pending_reqs.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_reqs != total_reqs) @(posedge i_clk);
        spin = 0;
        while (predicted_views.size() != 0 && spin < 1000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (10) @(posedge i_clk);
        if (predicted_views.size() != 0) begin
            fail_count++;
            $error("%0d predicted results never arrived", predicted_views.size());
        end

        $display("deque run: %0d requests, %0d results checked, %0d refused", total_reqs,
                 results_seen, rejected_seen);
        $display("deque run: full after %0d requests, empty after %0d, %0d failures",
                 full_seen, empty_seen, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
src/ddq_pkg.sv
src/ddq_cell.sv
src/ddq_chain.sv
src/double_ended_queue.sv
src/ddq_checker.sv
test/tb_double_ended_queue.sv
